[hw/rtl/icache_tag_and_miss_tracker_assert.svh]
// Assertion macros shared by the icache tag and miss tracker RTL.
`ifndef ICACHE_TAG_AND_MISS_TRACKER_ASSERT_SVH
`define ICACHE_TAG_AND_MISS_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk, switched off while in reset.
`define ICTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define ICTM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICTM_ASSERT(lbl, prop, msg)
`define ICTM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[hw/rtl/ictm_pkg.sv]
// Shared constants, types and helper functions of the icache tag and miss tracker.
`default_nettype none

package ictm_pkg;

  localparam int SETS         = 32;
  localparam int WAYS         = 4;
  localparam int LINE_BYTES   = 64;
  localparam int MSHR_ENTRIES = 4;
  localparam int ADDR_BITS    = 32;

  localparam int FIELD_W  = 32;
  localparam int EFF_BITS = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam int OFF_W    = $clog2(LINE_BYTES);
  localparam int SET_LOG  = $clog2(SETS);
  localparam int SET_W    = (SET_LOG > 0) ? SET_LOG : 1;
  localparam int WAY_LOG  = $clog2(WAYS);
  localparam int WAY_W    = (WAY_LOG > 0) ? WAY_LOG : 1;
  localparam int SLOT_LOG = $clog2(MSHR_ENTRIES);
  localparam int SLOT_W   = (SLOT_LOG > 0) ? SLOT_LOG : 1;
  localparam int LINE_W   = EFF_BITS - OFF_W;
  localparam int LTAG_W   = LINE_W - SET_LOG;
  localparam int WTAG_W   = FIELD_W + LTAG_W;

  localparam logic [FIELD_W-1:0] ADDR_MASK = {FIELD_W{1'b1}} >> (FIELD_W - EFF_BITS);
  localparam logic [15:0]        LFSR_SEED = 16'hACE1;

  typedef enum logic [1:0] {
    ACT_FETCH = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_INVAL = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef logic [FIELD_W-1:0]           root_t;
  typedef logic [LINE_W-1:0]            line_t;
  typedef logic [WTAG_W-1:0]            wtag_t;
  typedef logic [WAYS-1:0][WTAG_W-1:0]  way_row_t;

  // tag RAM write / clear request
  typedef struct packed {
    logic              en;
    logic              clr;
    logic [SET_W-1:0]  set;
    logic [WAY_W-1:0]  way;
    wtag_t             tag;
  } tram_wr_t;

  // miss slot read port
  typedef struct packed {
    logic  valid;
    line_t line;
    root_t root;
  } mshr_rd_t;

  // miss slot match / free search
  typedef struct packed {
    logic              match;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } mshr_look_t;

  // miss slot update
  typedef struct packed {
    logic              alloc;
    logic              retire;
    logic              clr;
    logic [SLOT_W-1:0] idx;
    line_t             line;
    root_t             root;
  } mshr_ctl_t;

  function automatic logic [SET_W-1:0] line_set(input line_t line);
    return SET_W'(line % SETS);
  endfunction

  function automatic logic [LTAG_W-1:0] line_tag(input line_t line);
    return LTAG_W'(line / SETS);
  endfunction

  function automatic wtag_t pack_tag(input root_t root, input line_t line);
    return {root, line_tag(line)};
  endfunction

  // Fibonacci LFSR, taps 16,14,13,11
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic b;
    b = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {b, v[15:1]};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ictm_tag_ram.sv]
// Set-organised tag memory with per-way valid flops and a registered read.
`default_nettype none

module ictm_tag_ram (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [ictm_pkg::SET_W-1:0] rd_set,
  input  ictm_pkg::tram_wr_t        wr,
  output ictm_pkg::way_row_t        rd_row,
  output logic [ictm_pkg::WAYS-1:0] rd_vld
);
  import ictm_pkg::*;

  way_row_t        mem [SETS];
  logic [WAYS-1:0] vld_r [SETS];
  way_row_t        rd_row_r;
  logic [WAYS-1:0] rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.set][wr.way] <= wr.tag;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) vld_r[s] <= '0;
    end else if (wr.clr) begin
      for (int s = 0; s < SETS; s++) vld_r[s] <= '0;
    end else if (wr.en) begin
      vld_r[wr.set][wr.way] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r <= vld_r[rd_set];
    end
  end

  assign rd_row = rd_row_r;
  assign rd_vld = rd_vld_r;

endmodule

`default_nettype wire

[hw/rtl/ictm_mshr.sv]
// Miss slot file: valid bits, line and root per slot, merge match and free-slot search.
`default_nettype none

module ictm_mshr (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ictm_pkg::SLOT_W-1:0] rd_idx,
  output ictm_pkg::mshr_rd_t          rd,
  input  ictm_pkg::line_t             lk_line,
  input  ictm_pkg::root_t             lk_root,
  output ictm_pkg::mshr_look_t        look,
  input  ictm_pkg::mshr_ctl_t         ctl
);
  import ictm_pkg::*;

  logic [MSHR_ENTRIES-1:0] vld_r;
  line_t                   line_r [MSHR_ENTRIES];
  root_t                   root_r [MSHR_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clr) begin
      vld_r <= '0;
    end else begin
      if (ctl.alloc)  vld_r[ctl.idx] <= 1'b1;
      if (ctl.retire) vld_r[ctl.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.alloc) begin
      line_r[ctl.idx] <= ctl.line;
      root_r[ctl.idx] <= ctl.root;
    end
  end

  assign rd.valid = vld_r[rd_idx];
  assign rd.line  = line_r[rd_idx];
  assign rd.root  = root_r[rd_idx];

  always_comb begin
    look = '0;
    for (int i = 0; i < MSHR_ENTRIES; i++) begin
      if (vld_r[i] && line_r[i] == lk_line && root_r[i] == lk_root) look.match = 1'b1;
      if (!vld_r[i] && !look.free_found) begin
        look.free_found = 1'b1;
        look.free_idx   = SLOT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/icache_tag_and_miss_tracker.sv]
// Top level of the icache tag and miss tracker.
// Each transaction passes through two steps: accept (tag RAM row read) and look-up/update.
// A new transaction is accepted only in idle, after the previous look-up has finished;
// a stalled result holds the look-up stage until the output register frees.
// Synchronous active-low reset clears all valid bits and miss slots at once, no sweep.
`default_nettype none

`include "icache_tag_and_miss_tracker_assert.svh"

module icache_tag_and_miss_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_page_root,
  input  logic [31:0] in_fetch_addr,
  input  logic [4:0]  in_warp_id,
  input  logic [1:0]  in_mshr_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fetch_valid,
  output logic        out_hit,
  output logic [4:0]  out_warp_out,
  output logic [31:0] out_addr_out,
  output logic        out_request_valid,
  output logic [31:0] out_request_block_addr,
  output logic [31:0] out_request_root,
  output logic [1:0]  out_request_slot,
  output logic        out_dropped,
  output logic        out_fill_error
);
  import ictm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // transaction held for the look-up cycle
  action_t      act_r;
  root_t        root_r;
  logic [31:0]  addr_r;
  logic [4:0]   warp_r;
  logic [1:0]   slot_r;
  logic         fill_ok_r;
  line_t        fill_line_r;
  root_t        fill_root_r;
  logic [15:0]  lfsr_r;

  logic         out_valid_r;
  logic         out_fetch_valid_r, out_fetch_valid_nxt;
  logic         out_hit_r, out_hit_nxt;
  logic [4:0]   out_warp_r, out_warp_nxt;
  logic [31:0]  out_addr_r, out_addr_nxt;
  logic         out_req_valid_r, out_req_valid_nxt;
  logic [31:0]  out_req_addr_r, out_req_addr_nxt;
  logic [31:0]  out_req_root_r, out_req_root_nxt;
  logic [1:0]   out_req_slot_r, out_req_slot_nxt;
  logic         out_dropped_r, out_dropped_nxt;
  logic         out_fill_err_r, out_fill_err_nxt;

  logic         accept;
  logic         look_done;
  logic [31:0]  in_addr_m;
  line_t        in_line;
  logic         in_slot_ok;
  logic [SET_W-1:0] rd_set;

  mshr_rd_t     mrd;
  mshr_look_t   mlook;
  mshr_ctl_t    mctl;
  tram_wr_t     twr;
  way_row_t     rd_row;
  logic [WAYS-1:0] rd_vld;

  line_t        line_c;
  wtag_t        key_c;
  logic         hit_c;
  logic         empty_found;
  logic [WAY_W-1:0] empty_way;
  logic [WAY_W-1:0] fill_way;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign look_done  = (state_r == ST_LOOK) && (!out_valid_r || out_ready);
  assign in_addr_m  = in_fetch_addr & ADDR_MASK;
  assign in_line    = LINE_W'(in_addr_m >> OFF_W);
  assign in_slot_ok = (int'(in_mshr_slot) < MSHR_ENTRIES);
  assign rd_set     = (in_action == ACT_FILL) ? line_set(mrd.line) : line_set(in_line);

  ictm_mshr u_mshr (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (SLOT_W'(in_mshr_slot)),
    .rd      (mrd),
    .lk_line (line_c),
    .lk_root (root_r),
    .look    (mlook),
    .ctl     (mctl)
  );

  ictm_tag_ram u_tag_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .rd_set (rd_set),
    .wr     (twr),
    .rd_row (rd_row),
    .rd_vld (rd_vld)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept)    state_nxt = ST_LOOK;
      ST_LOOK: if (look_done) state_nxt = ST_IDLE;
      default:                state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r       <= action_t'(in_action);
      root_r      <= in_page_root;
      addr_r      <= in_addr_m;
      warp_r      <= in_warp_id;
      slot_r      <= in_mshr_slot;
      // fill slot contents cannot change before the look-up cycle
      fill_ok_r   <= in_slot_ok && mrd.valid;
      fill_line_r <= mrd.line;
      fill_root_r <= mrd.root;
    end
  end

  // hit and victim selection on the registered row
  always_comb begin
    line_c      = LINE_W'(addr_r >> OFF_W);
    key_c       = pack_tag(root_r, line_c);
    hit_c       = 1'b0;
    empty_found = 1'b0;
    empty_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_vld[w] && rd_row[w] == key_c) hit_c = 1'b1;
      if (!rd_vld[w] && !empty_found) begin
        empty_found = 1'b1;
        empty_way   = WAY_W'(w);
      end
    end
    fill_way = empty_found ? empty_way : WAY_W'(lfsr_r % 16'(WAYS));
  end

  always_comb begin
    mctl        = '0;
    mctl.line   = line_c;
    mctl.root   = root_r;
    mctl.alloc  = look_done && (act_r == ACT_FETCH) && !hit_c && !mlook.match
                  && mlook.free_found;
    mctl.retire = look_done && (act_r == ACT_FILL) && fill_ok_r;
    mctl.clr    = look_done && (act_r == ACT_INVAL);
    mctl.idx    = mctl.alloc ? mlook.free_idx : SLOT_W'(slot_r);

    twr         = '0;
    twr.en      = mctl.retire;
    twr.clr     = mctl.clr;
    twr.set     = line_set(fill_line_r);
    twr.way     = fill_way;
    twr.tag     = pack_tag(fill_root_r, fill_line_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
    end else if (mctl.retire && !empty_found) begin
      lfsr_r <= lfsr_next(lfsr_r);
    end
  end

  always_comb begin
    out_fetch_valid_nxt = 1'b0;
    out_hit_nxt         = 1'b0;
    out_warp_nxt        = '0;
    out_addr_nxt        = '0;
    out_req_valid_nxt   = 1'b0;
    out_req_addr_nxt    = '0;
    out_req_root_nxt    = '0;
    out_req_slot_nxt    = '0;
    out_dropped_nxt     = 1'b0;
    out_fill_err_nxt    = 1'b0;
    case (act_r)
      ACT_FETCH: begin
        out_fetch_valid_nxt = 1'b1;
        out_hit_nxt         = hit_c;
        out_warp_nxt        = warp_r;
        out_addr_nxt        = addr_r;
        if (!hit_c && !mlook.match) begin
          if (mlook.free_found) begin
            out_req_valid_nxt = 1'b1;
            out_req_addr_nxt  = 32'(line_c) << OFF_W;
            out_req_root_nxt  = root_r;
            out_req_slot_nxt  = 2'(mlook.free_idx);
          end else begin
            out_dropped_nxt = 1'b1;
          end
        end
      end
      ACT_FILL: out_fill_err_nxt = !fill_ok_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (look_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_done) begin
      out_fetch_valid_r <= out_fetch_valid_nxt;
      out_hit_r         <= out_hit_nxt;
      out_warp_r        <= out_warp_nxt;
      out_addr_r        <= out_addr_nxt;
      out_req_valid_r   <= out_req_valid_nxt;
      out_req_addr_r    <= out_req_addr_nxt;
      out_req_root_r    <= out_req_root_nxt;
      out_req_slot_r    <= out_req_slot_nxt;
      out_dropped_r     <= out_dropped_nxt;
      out_fill_err_r    <= out_fill_err_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_fetch_valid        = out_fetch_valid_r;
  assign out_hit                = out_hit_r;
  assign out_warp_out           = out_warp_r;
  assign out_addr_out           = out_addr_r;
  assign out_request_valid      = out_req_valid_r;
  assign out_request_block_addr = out_req_addr_r;
  assign out_request_root       = out_req_root_r;
  assign out_request_slot       = out_req_slot_r;
  assign out_dropped            = out_dropped_r;
  assign out_fill_error         = out_fill_err_r;

  `ICTM_ASSERT_RST(a_reset_idle, (!rst_n) |=> (state_r == ST_IDLE && !out_valid_r), "reset did not idle the tracker")
  `ICTM_ASSERT(a_accept_look, (in_valid && in_ready) |=> (state_r == ST_LOOK), "accepted transaction did not reach look-up")
  `ICTM_ASSERT(a_look_loads_out, look_done |=> out_valid_r, "look-up finished without a result")
  `ICTM_ASSERT(a_stall_holds, (state_r == ST_LOOK && !look_done) |=> (state_r == ST_LOOK && $stable(act_r)), "stalled look-up lost its transaction")
  `ICTM_ASSERT(a_req_on_miss, (out_valid_r && out_req_valid_r) |-> (out_fetch_valid_r && !out_hit_r && !out_dropped_r), "line request without a fetch miss")

endmodule

`default_nettype wire
